FILE: design/plist_pkg.sv
package plist_pkg;

  // Request kinds carried on in_tuser.
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_DUMP   = 2'd2;

  // Status codes carried on out_tuser.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Field widths fixed by the interface.
  localparam int unsigned POS_W   = 8;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 7;

  // Widest cell index for the largest supported capacity (64 entries).
  localparam int unsigned AT_W = 6;

  // Edit command from the controller to the cell row.
  typedef struct packed {
    logic            ins;
    logic            del;
    logic [AT_W-1:0] at;
  } cell_op_t;

endpackage

FILE: design/plist_cells.sv
module plist_cells #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned IW       = 4
) (
  input  logic                      clk,
  input  plist_pkg::cell_op_t       op,
  input  logic [31:0]               wdata,
  input  logic [IW-1:0]             rd_idx,
  output logic [31:0]               rd_data
);
  import plist_pkg::*;

  logic [DATA_W-1:0] cells_r   [CAPACITY];
  logic [DATA_W-1:0] cells_nxt [CAPACITY];

  // Each cell picks its own value, its left neighbor's, its right neighbor's or
  // the new word, so an insert or a delete is one parallel shift.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [AT_W:0] at_x;
    logic [AT_W:0] idx_x;
    assign at_x  = {1'b0, op.at};
    assign idx_x = (AT_W + 1)'(i);

    always_comb begin
      cells_nxt[i] = cells_r[i];
      if (op.ins) begin
        if (idx_x == at_x) begin
          cells_nxt[i] = wdata;
        end else if (idx_x > at_x) begin
          cells_nxt[i] = cells_r[(i == 0) ? 0 : i - 1];
        end
      end else if (op.del) begin
        if (idx_x >= at_x && i < CAPACITY - 1) begin
          cells_nxt[i] = cells_r[(i >= CAPACITY - 1) ? i : i + 1];
        end
      end
    end

    always_ff @(posedge clk) begin
      cells_r[i] <= cells_nxt[i];
    end
  end

  // Read port for the dump sequencer.
  assign rd_data = cells_r[rd_idx];

endmodule

FILE: design/positional_list_store.sv
// Ordered list of signed 32-bit words with positional insert and delete and a
// full dump, holding at most CAPACITY entries.
// Input channel: in_tuser carries the request kind (0 insert, 1 delete, 2 dump),
// in_tdata the position (signed, 0 is the head) and the word to insert.
// Result channel: out_tuser carries the status and an entry flag, out_tdata the
// dumped entry and the count after the request, out_tlast marks the final
// result of a request.
// Insert and delete finish in the cycle they are accepted: their single result
// appears in the output register in the next cycle, and a new request is taken
// every cycle while the receiver keeps up. A dump of N entries produces N
// results, one per cycle from the output register while the receiver keeps up,
// reading the cell row by a counter; no request is taken until the last of them is loaded.
// Reset empties the list; the cell contents stay as they were and are never
// read beyond the count. When the receiver stalls, the output register holds
// its result and in_tready falls until the register can be reloaded.
module positional_list_store #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] position, [39:8] value
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] entry, [38:32] count, [39] zero
  output logic [2:0]  out_tuser,  // [1:0] status, [2] entry_valid
  output logic        out_tlast
);
  import plist_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Control state.
  logic [CW-1:0] count_r, count_nxt;
  logic          dumping_r, dumping_nxt;
  logic [IW-1:0] dump_idx_r, dump_idx_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Result payload.
  logic [1:0]        out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_entry_r, out_entry_nxt;
  logic              out_entry_valid_r, out_entry_valid_nxt;
  logic [CW-1:0]     out_count_r, out_count_nxt;
  logic              out_last_r, out_last_nxt;

  logic              slot_free;
  logic              accept;
  logic [1:0]        req_type;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] value;
  logic              pos_neg;
  logic [POS_W-1:0]  pos_u;
  logic [POS_W-1:0]  cnt_x;
  logic              pos_beyond;
  logic              is_full;
  logic              is_empty;
  logic              dump_last;
  cell_op_t          op;
  logic [IW-1:0]     rd_idx;
  logic [DATA_W-1:0] rd_data;

  assign req_type = in_tuser;
  assign position = in_tdata[POS_W-1:0];
  assign value    = in_tdata[POS_W +: DATA_W];

  // Handshake: the output register frees up when empty or being taken.
  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = slot_free && !dumping_r;
  assign accept    = in_tvalid && in_tready;

  // Position checks against the current count.
  assign pos_neg    = position[POS_W-1];
  assign pos_u      = {1'b0, position[POS_W-2:0]};
  assign cnt_x      = POS_W'(count_r);
  assign pos_beyond = pos_u >= cnt_x;
  assign is_full    = count_r == CW'(CAPACITY);
  assign is_empty   = count_r == '0;
  assign dump_last  = (CW'(dump_idx_r) + CW'(1)) == count_r;

  assign rd_idx = dumping_r ? dump_idx_r : '0;

  plist_cells #(
    .CAPACITY (CAPACITY),
    .IW       (IW)
  ) u_cells (
    .clk     (clk),
    .op      (op),
    .wdata   (value),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  // Request decode and dump sequencing.
  always_comb begin
    count_nxt           = count_r;
    dumping_nxt         = dumping_r;
    dump_idx_nxt        = dump_idx_r;
    out_valid_nxt       = out_valid_r && !out_tready;
    out_status_nxt      = out_status_r;
    out_entry_nxt       = out_entry_r;
    out_entry_valid_nxt = out_entry_valid_r;
    out_count_nxt       = out_count_r;
    out_last_nxt        = out_last_r;
    op                  = '0;

    if (dumping_r && slot_free) begin
      out_valid_nxt       = 1'b1;
      out_status_nxt      = ST_OK;
      out_entry_nxt       = rd_data;
      out_entry_valid_nxt = 1'b1;
      out_count_nxt       = count_r;
      out_last_nxt        = dump_last;
      dumping_nxt         = !dump_last;
      dump_idx_nxt        = dump_idx_r + IW'(1);
    end else if (accept) begin
      out_valid_nxt       = 1'b1;
      out_status_nxt      = ST_OK;
      out_entry_nxt       = '0;
      out_entry_valid_nxt = 1'b0;
      out_last_nxt        = 1'b1;
      unique case (req_type)
        REQ_INSERT: begin
          if (pos_neg) begin
            out_status_nxt = ST_INVALID;
          end else if (is_full) begin
            out_status_nxt = ST_FULL;
          end else begin
            op.ins    = 1'b1;
            op.at     = pos_beyond ? AT_W'(count_r) : AT_W'(pos_u);
            count_nxt = count_r + CW'(1);
          end
        end
        REQ_DELETE: begin
          if (is_empty) begin
            out_status_nxt = ST_EMPTY;
          end else if (pos_neg || pos_beyond) begin
            out_status_nxt = ST_INVALID;
          end else begin
            op.del    = 1'b1;
            op.at     = AT_W'(pos_u);
            count_nxt = count_r - CW'(1);
          end
        end
        REQ_DUMP: begin
          if (is_empty) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            out_entry_nxt       = rd_data;
            out_entry_valid_nxt = 1'b1;
            out_last_nxt        = count_r == CW'(1);
            dumping_nxt         = count_r != CW'(1);
            dump_idx_nxt        = IW'(1);
          end
        end
        default: begin
          out_status_nxt = ST_INVALID;
        end
      endcase
      out_count_nxt = count_nxt;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      dumping_r   <= 1'b0;
      dump_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      dumping_r   <= dumping_nxt;
      dump_idx_r  <= dump_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    out_status_r      <= out_status_nxt;
    out_entry_r       <= out_entry_nxt;
    out_entry_valid_r <= out_entry_valid_nxt;
    out_count_r       <= out_count_nxt;
    out_last_r        <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, COUNT_W'(out_count_r), out_entry_r};
  assign out_tuser  = {out_entry_valid_r, out_status_r};
  assign out_tlast  = out_last_r;

  // The count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("list count above capacity");

  // A pending non-final result only occurs in the middle of a dump.
  a_mid_dump: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> dumping_r)
    else $error("non-final result outside a dump");

  // Results without an entry are single results with a zero entry.
  a_plain_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_entry_valid_r |-> out_last_r && out_entry_r == '0)
    else $error("status result malformed");

  // A successful insert grows the list by one.
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && req_type == REQ_INSERT && !pos_neg && !is_full
    |=> count_r == $past(count_r) + CW'(1))
    else $error("insert did not grow the list");

  // No request is taken while a dump is running.
  a_dump_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    dumping_r |-> !accept && op == '0)
    else $error("request taken during dump");

endmodule

FILE: dv/list_result_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the list store, keeps its own copy of the list and
// compares every result against the results predicted for each request.
module list_result_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] position, [39:8] value
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // [31:0] entry, [38:32] count, [39] zero
  input  logic [2:0]  out_tuser,  // [1:0] status, [2] entry_valid
  input  logic        out_tlast,
  output int          fail_count,
  output int          results_due,
  output int          results_checked,
  output int          deepest_list
);

  import plist_pkg::*;

  typedef struct packed {
    logic [1:0]         status;
    logic [DATA_W-1:0]  entry;
    logic               entry_valid;
    logic [COUNT_W-1:0] count;
    logic               last;
  } list_result_t;

  list_result_t      pending_results [$];
  logic [DATA_W-1:0] cells [CAPACITY];
  int                held = 0;
  int                mismatches = 0;
  int                compared = 0;
  int                peak = 0;

  assign fail_count      = mismatches;
  assign results_due     = pending_results.size();
  assign results_checked = compared;
  assign deepest_list    = peak;

  // Queue one result; the count field always reflects the list after the request.
  function automatic void queue_result(input logic [1:0] status,
                                       input logic [DATA_W-1:0] entry,
                                       input logic valid, input logic last);
    list_result_t r;
    r.status      = status;
    r.entry       = entry;
    r.entry_valid = valid;
    r.count       = COUNT_W'(held);
    r.last        = last;
    pending_results.push_back(r);
  endfunction

  // Apply one accepted request to the shadow list and predict its results.
  function automatic void apply_list_request(input logic [1:0] kind,
                                             input logic signed [POS_W-1:0] pos,
                                             input logic [DATA_W-1:0] word);
    int p;
    int at;
    int i;
    p = pos;
    case (kind)
      REQ_INSERT: begin
        if (p < 0) begin
          queue_result(ST_INVALID, '0, 1'b0, 1'b1);
        end else if (held >= CAPACITY) begin
          queue_result(ST_FULL, '0, 1'b0, 1'b1);
        end else begin
          // Positions past the tail append.
          at = (p > held) ? held : p;
          for (i = held; i > at; i--) cells[i] = cells[i-1];
          cells[at] = word;
          held++;
          if (held > peak) peak = held;
          queue_result(ST_OK, '0, 1'b0, 1'b1);
        end
      end
      REQ_DELETE: begin
        if (held == 0) begin
          queue_result(ST_EMPTY, '0, 1'b0, 1'b1);
        end else if (p < 0 || p >= held) begin
          queue_result(ST_INVALID, '0, 1'b0, 1'b1);
        end else begin
          for (i = p; i + 1 < held; i++) cells[i] = cells[i+1];
          held--;
          queue_result(ST_OK, '0, 1'b0, 1'b1);
        end
      end
      REQ_DUMP: begin
        if (held == 0) begin
          queue_result(ST_EMPTY, '0, 1'b0, 1'b1);
        end else begin
          for (i = 0; i < held; i++) queue_result(ST_OK, cells[i], 1'b1, i + 1 == held);
        end
      end
      default: begin
        // The spare request code is refused like a bad position.
        queue_result(ST_INVALID, '0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  // Requests are modeled before results are popped, so ordering within an edge is safe.
  always @(posedge clk) begin : watch
    list_result_t want;
    if (!rst_n) begin
      held = 0;
      pending_results.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        apply_list_request(in_tuser, in_tdata[POS_W-1:0], in_tdata[POS_W +: DATA_W]);
      end
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual tdata 0x%0h tuser 0x%0h",
                   $time, out_tdata, out_tuser);
        end else begin
          want = pending_results.pop_front();
          compare_field("status", 32'(want.status), 32'(out_tuser[1:0]));
          compare_field("entry_valid", 32'(want.entry_valid), 32'(out_tuser[2]));
          compare_field("entry", want.entry, out_tdata[31:0]);
          compare_field("count", 32'(want.count), 32'(out_tdata[38:32]));
          compare_field("last", 32'(want.last), 32'(out_tlast));
          compared++;
        end
      end
    end
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  import plist_pkg::*;

  localparam int unsigned LIST_CAP = 16;
  // Request code with no defined meaning; the store must refuse it.
  localparam logic [1:0] REQ_SPARE = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // [7:0] position, [39:8] value
  logic [1:0]  in_tuser;   // [1:0] req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [31:0] entry, [38:32] count, [39] zero
  logic [2:0]  out_tuser;  // [1:0] status, [2] entry_valid
  logic        out_tlast;

  int fail_count;
  int results_due;
  int results_checked;
  int deepest_list;
  int idle_pct = 0;
  int stall_pct = 0;
  int requests_sent = 0;

  positional_list_store #(.CAPACITY(LIST_CAP)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  list_result_checker #(.CAPACITY(LIST_CAP)) u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .fail_count     (fail_count),
    .results_due    (results_due),
    .results_checked(results_checked),
    .deepest_list   (deepest_list)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Present one request, after optional idle cycles, and wait for its acceptance.
  task automatic issue_request(input logic [1:0] kind, input logic [7:0] pos,
                               input logic [31:0] word);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {word, pos};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
  endtask

  // Random request; grow_pct steers the list toward full or toward empty.
  task automatic random_request(input int grow_pct);
    logic [1:0]  kind;
    logic [7:0]  pos;
    logic [31:0] word;
    int          roll;
    roll = $urandom_range(99);
    if (roll < grow_pct) kind = REQ_INSERT;
    else if (roll < 86) kind = REQ_DELETE;
    else if (roll < 97) kind = REQ_DUMP;
    else kind = REQ_SPARE;
    roll = $urandom_range(99);
    if (roll < 75) pos = 8'($urandom_range(LIST_CAP - 1));
    else if (roll < 85) pos = 8'($urandom_range(127, LIST_CAP));
    else pos = 8'($urandom_range(255));
    roll = $urandom_range(99);
    case (roll % 8)
      0: word = 32'h8000_0000;
      1: word = 32'h7FFF_FFFF;
      2: word = (roll < 50) ? 32'hFFFF_FFFF : 32'h0;
      default: word = $urandom;
    endcase
    issue_request(kind, pos, word);
  endtask

  initial begin
    int ph;
    int n;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= REQ_INSERT;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list, bad positions, extremes, spare code, then fill to full.
    issue_request(REQ_DUMP, 8'd0, 32'h0);
    issue_request(REQ_DELETE, 8'd0, 32'h0);
    issue_request(REQ_INSERT, 8'h80, 32'h1234_5678);
    issue_request(REQ_INSERT, 8'd127, 32'h7FFF_FFFF);
    issue_request(REQ_INSERT, 8'd0, 32'h8000_0000);
    issue_request(REQ_INSERT, 8'd1, 32'hFFFF_FFFF);
    issue_request(REQ_DUMP, 8'hFF, 32'hFFFF_FFFF);
    issue_request(REQ_DELETE, 8'hFF, 32'h0);
    issue_request(REQ_DELETE, 8'd3, 32'h0);
    issue_request(REQ_DELETE, 8'd1, 32'h0);
    issue_request(REQ_SPARE, 8'd0, 32'hA5A5_A5A5);
    issue_request(REQ_INSERT, 8'd2, 32'h0);
    for (n = 3; n < LIST_CAP; n++) issue_request(REQ_INSERT, 8'(n % 5), $urandom);
    issue_request(REQ_INSERT, 8'd5, 32'hDEAD_BEEF);
    issue_request(REQ_INSERT, 8'hFF, 32'hDEAD_BEEF);
    issue_request(REQ_DUMP, 8'd0, 32'h0);

    // Random phases: free-running, sparse sender, stalled receiver, both.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 80; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 80; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      for (n = 0; n < 110; n++) random_request(((n / 32) % 2 == 0) ? 62 : 22);
      // Let the store drain completely once before the stalled phase.
      if (ph == 1) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
    stall_pct = 0;

    while (results_due != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d requests over four handshake phases, directed and random.",
             requests_sent);
    $display("Compared %0d results; the list reached %0d of %0d entries.",
             results_checked, deepest_list, LIST_CAP);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches found.", fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hang guard, far above the slowest legal run.
  initial begin
    #8_000_000;
    $display("Timed out with %0d results still outstanding.", results_due);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
